FILE: hdl/adaptive_dema_filter_core_assert.svh
// assertion macros for the dema filter core
`ifndef ADAPTIVE_DEMA_FILTER_CORE_ASSERT_SVH
`define ADAPTIVE_DEMA_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is low
`define ADF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property that also holds during reset
`define ADF_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADF_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADF_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/adf_pkg.sv
package adf_pkg;

  // field and register widths
  localparam int SAMPLE_BITS     = 24;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int CUTOFF_W        = 10;
  localparam int ELAPSED_W       = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = (SAMPLE_BITS > CUTOFF_W) ? SAMPLE_BITS : CUTOFF_W;
  localparam int OUT_W           = SAMPLE_BITS + 2;
  localparam int IN_DATA_W       = ((SAMPLE_BITS + ELAPSED_W + 7) / 8) * 8;
  localparam int OUT_DATA_W      = ((OUT_W + 7) / 8) * 8;

  // alpha datapath widths
  localparam int PROD_W  = CUTOFF_W + ELAPSED_W;
  localparam int P_W     = 29;
  localparam int DEN_W   = P_W + 3;
  localparam int ALPHA_W = ALPHA_FRAC_BITS - 2;
  localparam int NUM_W   = DEN_W + ALPHA_W;
  localparam int ACC_W   = SAMPLE_BITS + ALPHA_FRAC_BITS;

  // shared multiplier
  localparam int MUL_W   = 32;
  localparam int MUL_P_W = 2 * MUL_W;

  // constants of the alpha formula
  localparam int TWO_PI_W = 19;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q   = TWO_PI_W'(411775);
  localparam logic [PROD_W-1:0]   PROD_LIMIT = PROD_W'(1000);
  localparam logic [P_W-1:0]      P_CLIP     = P_W'(64'd411775 * 64'd500);
  localparam logic [P_W-1:0]      P_THOUSAND = P_W'(64'd1000 << 16);

  // register reset values
  localparam logic [CUTOFF_W-1:0]    CUTOFF_RESET = CUTOFF_W'(8);
  localparam logic [SAMPLE_BITS-1:0] LEVEL_RESET  = SAMPLE_BITS'(14995);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCALE,
    ST_DEN,
    ST_DIV_GO,
    ST_DIV,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_DONE
  } adf_state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } adf_div_stat_t;

endpackage

FILE: hdl/adaptive_dema_filter_core.sv
// Double exponential moving average with a time-adaptive smoothing factor.
// Each input beat carries a Q4.20 sample and the milliseconds since the last
// one; the block derives alpha = dt/(dt+RC)/8 from cutoff_hz (clipped when the
// cutoff exceeds the sample rate), updates two cascaded averages and returns
// one beat holding 2*first - second as a signed Q6.20 value. The block takes no
// new beat until the sequencer is back in idle after the result is written. The
// time per item is set by the restoring divider for alpha, which makes one of its
// 14 quotient bits per cycle, plus six multiply steps on the one shared 32x32
// multiplier. A result held by the receiver stalls the sequencer in its last step.
// Writing initial_level reloads both averages; cutoff_hz and initial_level reset
// to 8 and 14995.
module adaptive_dema_filter_core
  import adf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample, elapsed_ms
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // filtered
);

`include "adaptive_dema_filter_core_assert.svh"

  adf_state_e state_q, state_d;

  logic [CUTOFF_W-1:0]    cutoff_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [ELAPSED_W-1:0]   ms_q;
  logic [PROD_W-1:0]      prod_q;
  logic [P_W-1:0]         p_q;
  logic [DEN_W-1:0]       den_q;
  logic [ALPHA_W-1:0]     alpha_q;
  logic [ACC_W-1:0]       acc_q;
  logic [SAMPLE_BITS-1:0] f_q;
  logic [SAMPLE_BITS-1:0] s_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_q;

  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [MUL_P_W-1:0]       mul_p;
  logic [ALPHA_FRAC_BITS:0] one_minus_alpha;
  logic [ACC_W-1:0]         acc_sum;
  logic [NUM_W-1:0]         dividend;
  logic                     div_start;
  logic [ALPHA_W-1:0]       div_quo;
  adf_div_stat_t            div_stat;
  logic                     in_beat;
  logic                     out_free;
  logic [OUT_W-1:0]         dema;

  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (ALPHA_FRAC_BITS - 1);
  localparam logic [ALPHA_FRAC_BITS:0] ALPHA_ONE = (ALPHA_FRAC_BITS + 1)'(1) << ALPHA_FRAC_BITS;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_beat) state_d = ST_PROD;
      ST_PROD:   state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_DEN;
      ST_DEN:    state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV:    if (div_stat.done) state_d = ST_M1;
      ST_M1:     state_d = ST_M2;
      ST_M2:     state_d = ST_M3;
      ST_M3:     state_d = ST_M4;
      ST_M4:     state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and divider start
  assign one_minus_alpha = ALPHA_ONE - {{(ALPHA_FRAC_BITS + 1 - ALPHA_W){1'b0}}, alpha_q};

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      ST_PROD: begin
        mul_a = MUL_W'(cutoff_q);
        mul_b = MUL_W'(ms_q);
      end
      ST_SCALE: begin
        mul_a = MUL_W'(TWO_PI_Q);
        mul_b = MUL_W'(prod_q);
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_M1: begin
        mul_a = MUL_W'(alpha_q);
        mul_b = MUL_W'(x_q);
      end
      ST_M2: begin
        mul_a = MUL_W'(one_minus_alpha);
        mul_b = MUL_W'(f_q);
      end
      ST_M3: begin
        mul_a = MUL_W'(alpha_q);
        mul_b = MUL_W'(f_q);
      end
      ST_M4: begin
        mul_a = MUL_W'(one_minus_alpha);
        mul_b = MUL_W'(s_q);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // shared multiplier
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // second half of an average update and the rounded dividend
  assign acc_sum  = acc_q + mul_p[ACC_W-1:0];
  assign dividend = {{(NUM_W - P_W - ALPHA_FRAC_BITS){1'b0}}, p_q, {ALPHA_FRAC_BITS{1'b0}}}
                  + {{(NUM_W - DEN_W + 1){1'b0}}, den_q[DEN_W-1:1]};

  adf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // 2*first - second, exact
  assign dema = {1'b0, f_q, 1'b0} - {2'b00, s_q};

  // control, configuration and average state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cutoff_q    <= CUTOFF_RESET;
      f_q         <= LEVEL_RESET;
      s_q         <= LEVEL_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && cfg_index_i == CFG_CUTOFF) begin
        cutoff_q <= cfg_data_i[CUTOFF_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_LEVEL) begin
        f_q <= cfg_data_i[SAMPLE_BITS-1:0];
        s_q <= cfg_data_i[SAMPLE_BITS-1:0];
      end else if (state_q == ST_M2) begin
        f_q <= acc_sum[ACC_W-1:ALPHA_FRAC_BITS];
      end else if (state_q == ST_M4) begin
        s_q <= acc_sum[ACC_W-1:ALPHA_FRAC_BITS];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q  <= s_axis_tdata[SAMPLE_BITS-1:0];
      ms_q <= s_axis_tdata[SAMPLE_BITS +: ELAPSED_W];
    end
    if (state_q == ST_PROD) begin
      prod_q <= mul_p[PROD_W-1:0];
    end
    if (state_q == ST_SCALE) begin
      // cutoff above the sample rate pins fc to half the rate
      p_q <= (prod_q > PROD_LIMIT) ? P_CLIP : mul_p[P_W-1:0];
    end
    if (state_q == ST_DEN) begin
      den_q <= {p_q + P_THOUSAND, 3'b000};
    end
    if (state_q == ST_DIV && div_stat.done) begin
      alpha_q <= div_quo;
    end
    if (state_q == ST_M1 || state_q == ST_M3) begin
      acc_q <= mul_p[ACC_W-1:0] + ACC_HALF;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= dema;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_W){1'b0}}, out_q};

  // checks
  `ADF_ASSERT(a_ready_div_idle, clk_i, rst_ni, s_axis_tready |-> !div_stat.busy, "ready while divider busy")
  `ADF_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_stat.done |-> (state_q == ST_DIV), "divider done outside divide step")
  `ADF_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE), "result valid without finished item")
  `ADF_ASSERT_NORST(a_reset_no_result, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

endmodule

FILE: hdl/adf_div.sv
module adf_div
  import adf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_W-1:0]     dividend_i,
  input  logic [DEN_W-1:0]     divisor_i,
  output logic [ALPHA_W-1:0]   quotient_o,
  output adf_div_stat_t        stat_o
);

  localparam int CNT_W = $clog2(ALPHA_W + 1);

  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [ALPHA_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]   dvs_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DEN_W:0]     shifted;
  logic [DEN_W:0]     diff;
  logic               ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[ALPHA_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i && cnt_q == '0) begin
      // upper part is below the divisor, so the quotient fits alpha width
      rem_d = dividend_i[NUM_W-1:ALPHA_W];
      quo_d = dividend_i[ALPHA_W-1:0];
      cnt_d = CNT_W'(ALPHA_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d  = {quo_q[ALPHA_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i && cnt_q == '0) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule
